@@ rtl/core/stmc_pkg.sv @@
// ----------------------------------------------------------------------------
// stmc_pkg : shared types and codes of the solar tracker motor controller
// Motor codes, register indexes and the tick control bundle that the top
// level hands to the mode unit.
// ----------------------------------------------------------------------------
package stmc_pkg;

	// motor command codes
	localparam logic [1:0] MOTOR_STOP  = 2'd0;
	localparam logic [1:0] MOTOR_RIGHT = 2'd1;
	localparam logic [1:0] MOTOR_LEFT  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_EN  = 3'd3;

	// reset value of the three level registers
	localparam int LEVEL_RESET = 200;

	// one tick as seen by the mode unit
	typedef struct packed {
		logic tick;      // tick processed this cycle
		logic overheat;  // temperature above limit
		logic level;     // raw button level, 0 pressed
	} mode_ctl_t;

endpackage

@@ rtl/core/stmc_mode.sv @@
// ----------------------------------------------------------------------------
// stmc_mode : button debouncer and standby mode
// Debounces the button level, toggles standby on an accepted press and
// forces standby while overheated (debouncer frozen then).
// ----------------------------------------------------------------------------
module stmc_mode #(
	parameter int DEBOUNCE_TICKS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stmc_pkg::mode_ctl_t ctl,
	output logic                standby_next
);
	import stmc_pkg::*;

	localparam int CW = $clog2(DEBOUNCE_TICKS + 1);

	logic          prev_q;
	logic [CW-1:0] count_q;
	logic          accepted_q;
	logic          standby_q;

	logic [CW-1:0] count_inc;
	logic          hit;
	logic          press;

	// steady count and acceptance for this tick
	always_comb begin
		count_inc = (ctl.level == prev_q) ? (count_q + CW'(1)) : '0;
		hit       = (count_inc >= CW'(DEBOUNCE_TICKS));
		press     = hit && (ctl.level != accepted_q) && !ctl.level;
		if (ctl.overheat) begin
			standby_next = 1'b1;
		end else if (press) begin
			standby_next = ~standby_q;
		end else begin
			standby_next = standby_q;
		end
	end

	// state update, once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 1'b1;
			count_q    <= '0;
			accepted_q <= 1'b1;
			standby_q  <= 1'b0;
		end else if (ctl.tick) begin
			standby_q <= standby_next;
			if (!ctl.overheat) begin
				prev_q  <= ctl.level;
				count_q <= hit ? '0 : count_inc;
				if (hit) begin
					accepted_q <= ctl.level;
				end
			end
		end
	end

endmodule

@@ rtl/core/solar_tracker_motor_controller.sv @@
// ----------------------------------------------------------------------------
// solar_tracker_motor_controller : tick-driven panel motor control
// Light compare, night stop, overheat standby and button mode toggle,
// with a report on each change of motor state while monitoring is enabled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | to block  | in_valid / in_stall  | left/right_light, temp, button
//  out     | from block| out_valid / out_stall| motor_drive, standby, report
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One tick per cycle while the result is not stalled; a request passes
//  the input register, then the result register.
//  A stalled result holds the result register; the input register still
//  takes one more request, after which in_stall follows out_stall.
//  Reset restores valid bits, motor state and config; cfg_ready is always high.
// ----------------------------------------------------------------------------
module solar_tracker_motor_controller #(
	parameter int DEBOUNCE_TICKS = 10,
	parameter int SAMPLE_BITS    = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [SAMPLE_BITS-1:0]           left_light,
	input  logic [SAMPLE_BITS-1:0]           right_light,
	input  logic [SAMPLE_BITS-1:0]           temp_sample,
	input  logic                             button_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       motor_drive,
	output logic                             standby_active,
	output logic                             report_valid,
	output logic [1:0]                       report_code,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_BITS-1:0]           cfg_data
);
	import stmc_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] RESET_LEVEL = SAMPLE_BITS'(LEVEL_RESET);

	// configuration registers
	logic [SAMPLE_BITS-1:0] turn_limit_q;
	logic [SAMPLE_BITS-1:0] night_level_q;
	logic [SAMPLE_BITS-1:0] max_temp_q;
	logic                   monitor_en_q;

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] left_s1;
	logic [SAMPLE_BITS-1:0] right_s1;
	logic [SAMPLE_BITS-1:0] temp_s1;
	logic                   button_s1;

	// result stage and motor state
	logic                   out_valid_q;
	logic [1:0]             motor_drive_q;
	logic                   standby_q;
	logic                   report_valid_q;
	logic [1:0]             report_code_q;
	logic [1:0]             motor_state_q;

	logic                   advance;
	logic                   tick;
	mode_ctl_t              mode_ctl;
	logic                   standby_next;
	logic [SAMPLE_BITS:0]   left_sum;
	logic [SAMPLE_BITS:0]   right_sum;
	logic [1:0]             motor_next;
	logic                   changed;

	// handshake
	assign advance   = !(out_valid_q && out_stall);
	assign tick      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// configuration writes; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_limit_q  <= RESET_LEVEL;
			night_level_q <= RESET_LEVEL;
			max_temp_q    <= RESET_LEVEL;
			monitor_en_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TURN_LIMIT:  turn_limit_q  <= cfg_data;
				CFG_NIGHT_LEVEL: night_level_q <= cfg_data;
				CFG_MAX_TEMP:    max_temp_q    <= cfg_data;
				CFG_MONITOR_EN:  monitor_en_q  <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			left_s1   <= left_light;
			right_s1  <= right_light;
			temp_s1   <= temp_sample;
			button_s1 <= button_level;
		end
	end

	// debouncer and standby mode
	assign mode_ctl.tick     = tick;
	assign mode_ctl.overheat = (temp_s1 > max_temp_q);
	assign mode_ctl.level    = button_s1;

	stmc_mode #(
		.DEBOUNCE_TICKS(DEBOUNCE_TICKS)
	) u_mode (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (mode_ctl),
		.standby_next (standby_next)
	);

	// motor decision: a - b > limit is a > b + limit
	always_comb begin
		left_sum  = {1'b0, left_s1} + {1'b0, turn_limit_q};
		right_sum = {1'b0, right_s1} + {1'b0, turn_limit_q};
		if (standby_next) begin
			motor_next = MOTOR_STOP;
		end else if ((left_s1 < night_level_q) && (right_s1 < night_level_q)) begin
			motor_next = MOTOR_STOP;
		end else if ({1'b0, right_s1} > left_sum) begin
			motor_next = MOTOR_RIGHT;
		end else if ({1'b0, left_s1} > right_sum) begin
			motor_next = MOTOR_LEFT;
		end else begin
			motor_next = MOTOR_STOP;
		end
		changed = (motor_next != motor_state_q);
	end

	// motor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			motor_state_q <= MOTOR_STOP;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				motor_state_q <= motor_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			motor_drive_q  <= motor_next;
			standby_q      <= standby_next;
			report_valid_q <= changed && monitor_en_q;
			report_code_q  <= (changed && monitor_en_q) ? motor_next : MOTOR_STOP;
		end
	end

	assign out_valid      = out_valid_q;
	assign motor_drive    = motor_drive_q;
	assign standby_active = standby_q;
	assign report_valid   = report_valid_q;
	assign report_code    = report_code_q;

endmodule

@@ rtl/core/stmc_checker.sv @@
// ----------------------------------------------------------------------------
// stmc_checker : port-level checks of the motor controller
// Result consistency and held results under stall; bound to the top level.
// ----------------------------------------------------------------------------
module stmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] motor_drive,
	input logic       standby_active,
	input logic       report_valid,
	input logic [1:0] report_code
);
	import stmc_pkg::*;

	// a report carries the motor state of the same result
	a_report_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_valid) |-> (report_code == motor_drive))
		else $error("report code differs from motor drive");

	// no report means code zero
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !report_valid) |-> (report_code == MOTOR_STOP))
		else $error("report code set without report");

	// standby always stops the motor
	a_standby_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && standby_active) |-> (motor_drive == MOTOR_STOP))
		else $error("motor runs in standby");

	// a report right after a taken reported result must carry a new motor code
	a_report_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && report_valid) |=>
		(!(out_valid && report_valid) || (report_code != $past(motor_drive))))
		else $error("report without change of motor state");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(motor_drive) && $stable(report_valid)))
		else $error("stalled result changed");

endmodule

bind solar_tracker_motor_controller stmc_checker u_stmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.motor_drive    (motor_drive),
	.standby_active (standby_active),
	.report_valid   (report_valid),
	.report_code    (report_code)
);
